>>> hdl/buddy_block_allocator_assert.svh
// assertion macros used by the buddy allocator controller
// expects clk and rst_n in the scope of use
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bba_pkg.sv
// types, constants and command codes of the buddy block allocator
// no dependencies
`default_nettype none
package bba_pkg;

    localparam int POOL_ORDER  = 8;
    localparam int POOL_UNITS  = 1 << POOL_ORDER;
    localparam int ORDER_COUNT = POOL_ORDER + 1;
    localparam int NODE_COUNT  = (2 << POOL_ORDER) - 1;
    localparam int UNIT_W      = POOL_ORDER;
    localparam int SIZE_W      = POOL_ORDER + 1;
    localparam int NODE_W      = POOL_ORDER + 1;
    localparam int ORD_W       = $clog2(ORDER_COUNT + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_NONE    = 2'd2,
        ST_TOO_BIG = 2'd3
    } status_t;

    typedef struct packed {
        logic              kind;
        logic [SIZE_W-1:0] request_size;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [UNIT_W-1:0] block_start;
        logic [UNIT_W-1:0] block_end;
        logic [SIZE_W-1:0] available;
    } out_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEARCH,
        OP_SPLIT,
        OP_PUSH,
        OP_POP,
        OP_LDS,
        OP_MERGE
    } op_t;

    typedef struct packed {
        op_t     op;
        logic    err;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic too_big;
        logic is_free;
        logic stack_empty;
        logic found;
        logic at_top;
        logic split_done;
        logic merge_stop;
    } stat_t;

endpackage
`default_nettype wire

>>> hdl/buddy_block_allocator.sv
// buddy block allocator top level: controller plus datapath
// depends on bba_pkg, bba_ctrl, bba_datapath
// channels: in_valid/in_ready/in_data takes one request item (kind 0 allocate,
//   1 free the last block of that size order, request_size); out_valid/out_ready/
//   out_data returns one result item per request (status, block_start,
//   block_end, available)
// after accept: a check, which ends a too-big or nothing-held request; an
//   allocate then searches the bitmaps up from its order (no free block if
//   none is found up to the top) and splits down a level per step to a push;
//   a free pops its stack, reads it and merges up a level per step
// throughput: one request in flight; in_ready is high only in idle, and the
//   next item may be taken while the last result still waits in the output
// reset: rst_n async low; the whole pool is one free block, all stacks are
//   empty and available reads 256; no clearing pass is needed
// stall: while out_ready is low and a result waits, the controller holds
//   before each step that could finish a request
`default_nettype none
module buddy_block_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bba_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output bba_pkg::out_t      out_data
);
    import bba_pkg::*;

    // command and status between sequencer and datapath
    cmd_t  cmd;
    stat_t stat;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // bitmaps, stacks and result register live here
    bba_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (out_data)
    );

endmodule
`default_nettype wire

>>> hdl/bba_datapath.sv
// datapath: per-order free bitmaps, allocation stacks, free count, result register
// depends on bba_pkg
`default_nettype none
module bba_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bba_pkg::in_t  in_data,
    input  wire bba_pkg::cmd_t cmd,
    output bba_pkg::stat_t     stat,
    output bba_pkg::out_t      result
);
    import bba_pkg::*;

    logic [POOL_UNITS-1:0] lvl_reg [ORDER_COUNT];
    logic [SIZE_W-1:0]     cnt_reg [ORDER_COUNT];
    logic [SIZE_W-1:0]     avail_reg;
    logic [UNIT_W-1:0]     stack_mem [NODE_COUNT];
    logic [UNIT_W-1:0]     rd_reg;

    logic [ORD_W-1:0]  x_reg;
    logic [ORD_W-1:0]  j_reg;
    logic              kind_reg;
    logic              big_reg;
    logic [UNIT_W-1:0] s_reg;
    logic [UNIT_W-1:0] m_reg;
    out_t              res_reg;

    logic [ORD_W-1:0]      order;
    logic [SIZE_W-1:0]     size_m1;
    logic [POOL_UNITS-1:0] lvl_cur;
    logic [UNIT_W-1:0]     ffs;
    logic                  any_free;
    logic [ORD_W-1:0]      jm1;
    logic [UNIT_W-1:0]     split_idx;
    logic [UNIT_W-1:0]     m_idx;
    logic [UNIT_W-1:0]     buddy_idx;
    logic [SIZE_W-1:0]     blk_size;
    logic [UNIT_W-1:0]     blk_end;
    logic [SIZE_W-1:0]     cnt_x;
    logic [NODE_W-1:0]     cap;
    logic [NODE_W-1:0]     wr_addr;
    logic [NODE_W-1:0]     rd_addr;
    logic                  at_top;

    // order of the request: bit length of size-1, zero for sizes 0 and 1
    always_comb
    begin
        size_m1 = in_data.request_size - SIZE_W'(1);
        order   = '0;
        if (in_data.request_size > SIZE_W'(1))
        begin
            for (int i = 0; i < SIZE_W; i++)
            begin
                if (size_m1[i])
                    order = ORD_W'(i + 1);
            end
        end
    end

    // lowest free block at the current level
    always_comb
    begin
        lvl_cur = lvl_reg[j_reg];
        ffs     = '0;
        for (int i = POOL_UNITS - 1; i >= 0; i--)
        begin
            if (lvl_cur[i])
                ffs = UNIT_W'(i);
        end
        any_free = |lvl_cur;
    end

    always_comb
    begin
        at_top    = (j_reg == ORD_W'(POOL_ORDER));
        jm1       = j_reg - ORD_W'(1);
        split_idx = (s_reg >> jm1) | UNIT_W'(1);
        m_idx     = m_reg >> j_reg;
        buddy_idx = m_idx ^ UNIT_W'(1);
        blk_size  = SIZE_W'(1) << x_reg;
        blk_end   = s_reg + UNIT_W'(blk_size - SIZE_W'(1));
        cnt_x     = cnt_reg[x_reg];
        cap       = NODE_W'(1) << (ORD_W'(POOL_ORDER) - x_reg);
        wr_addr   = cap - NODE_W'(1) + NODE_W'(cnt_x);
        rd_addr   = wr_addr - NODE_W'(1);
    end

    always_comb
    begin
        stat.too_big     = big_reg;
        stat.is_free     = kind_reg;
        stat.stack_empty = (cnt_x == '0);
        stat.found       = any_free;
        stat.at_top      = at_top;
        stat.split_done  = (j_reg == x_reg);
        stat.merge_stop  = at_top || !lvl_cur[buddy_idx];
    end

    assign result = res_reg;

    // control state: bitmaps, stack fill counts, free count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // only the whole-pool block starts free
            for (int k = 0; k < ORDER_COUNT; k++)
            begin
                lvl_reg[k] <= (k == POOL_ORDER) ? POOL_UNITS'(1) : '0;
                cnt_reg[k] <= '0;
            end
            avail_reg <= SIZE_W'(POOL_UNITS);
        end
        else
        begin
            unique case (cmd.op)
                OP_SEARCH:
                begin
                    if (any_free)
                        lvl_reg[j_reg][ffs] <= 1'b0;
                end
                OP_SPLIT:
                    lvl_reg[jm1][split_idx] <= 1'b1;
                OP_PUSH:
                begin
                    if (NODE_W'(cnt_x) < cap)
                        cnt_reg[x_reg] <= cnt_x + SIZE_W'(1);
                    avail_reg <= avail_reg - blk_size;
                end
                OP_POP:
                    cnt_reg[x_reg] <= cnt_x - SIZE_W'(1);
                OP_MERGE:
                begin
                    if (stat.merge_stop)
                    begin
                        lvl_reg[j_reg][m_idx] <= 1'b1;
                        avail_reg <= avail_reg + blk_size;
                    end
                    else
                        lvl_reg[j_reg][buddy_idx] <= 1'b0;
                end
                OP_NONE, OP_LOAD, OP_LDS:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers and result
    always_ff @(posedge clk)
    begin
        if (cmd.err)
            res_reg <= '{status: cmd.code, block_start: '0, block_end: '0,
                         available: avail_reg};
        unique case (cmd.op)
            OP_LOAD:
            begin
                x_reg    <= order;
                j_reg    <= order;
                kind_reg <= in_data.kind;
                big_reg  <= (in_data.request_size > SIZE_W'(POOL_UNITS));
            end
            OP_SEARCH:
            begin
                if (any_free)
                    s_reg <= ffs << j_reg;
                else
                    j_reg <= j_reg + ORD_W'(1);
            end
            OP_SPLIT:
                j_reg <= jm1;
            OP_PUSH:
                res_reg <= '{status: ST_OK, block_start: s_reg, block_end: blk_end,
                             available: avail_reg - blk_size};
            OP_LDS:
            begin
                s_reg <= rd_reg;
                m_reg <= rd_reg;
            end
            OP_MERGE:
            begin
                if (stat.merge_stop)
                    res_reg <= '{status: ST_OK, block_start: s_reg, block_end: blk_end,
                                 available: avail_reg + blk_size};
                else
                begin
                    m_reg <= m_reg & ~(UNIT_W'(1) << j_reg);
                    j_reg <= j_reg + ORD_W'(1);
                end
            end
            OP_NONE, OP_POP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // allocation stacks, one per order, laid out back to back
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_PUSH && NODE_W'(cnt_x) < cap)
            stack_mem[wr_addr] <= s_reg;
        rd_reg <= stack_mem[rd_addr];
    end

endmodule
`default_nettype wire

>>> hdl/bba_ctrl.sv
// controller: sequences search, split, pop and merge steps; owns output valid
// depends on bba_pkg and buddy_block_allocator_assert.svh
`default_nettype none
`include "buddy_block_allocator_assert.svh"
module bba_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire bba_pkg::stat_t stat,
    output bba_pkg::cmd_t       cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_SPLIT,
        S_WAIT,
        S_MERGE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   slot_free;
    logic   fin;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NONE, err: 1'b0, code: ST_OK};
        fin        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (slot_free)
                begin
                    priority if (stat.too_big)
                    begin
                        cmd.err  = 1'b1;
                        cmd.code = ST_TOO_BIG;
                        fin      = 1'b1;
                    end
                    else if (!stat.is_free)
                        state_next = S_SEARCH;
                    else if (stat.stack_empty)
                    begin
                        cmd.err  = 1'b1;
                        cmd.code = ST_NONE;
                        fin      = 1'b1;
                    end
                    else
                    begin
                        cmd.op     = OP_POP;
                        state_next = S_WAIT;
                    end
                end
            end
            S_SEARCH:
            begin
                if (slot_free)
                begin
                    cmd.op = OP_SEARCH;
                    priority if (stat.found)
                        state_next = S_SPLIT;
                    else if (stat.at_top)
                    begin
                        cmd.err  = 1'b1;
                        cmd.code = ST_NO_FREE;
                        fin      = 1'b1;
                    end
                    else
                        state_next = S_SEARCH;  // climb one order
                end
            end
            S_SPLIT:
            begin
                if (slot_free)
                begin
                    if (stat.split_done)
                    begin
                        cmd.op = OP_PUSH;
                        fin    = 1'b1;
                    end
                    else
                        cmd.op = OP_SPLIT;
                end
            end
            S_WAIT:
            begin
                cmd.op     = OP_LDS;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (slot_free)
                begin
                    cmd.op = OP_MERGE;
                    fin    = stat.merge_stop;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (fin)
            state_next = S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    `BBA_ASSERT_IMP(a_no_overwrite, fin, !out_valid_reg || out_ready, "result overwritten")
    `BBA_ASSERT_NXT(a_load_check, in_valid && in_ready, state_reg == S_CHECK, "load not checked")
    `BBA_ASSERT_NXT(a_wait_one, state_reg == S_WAIT, state_reg == S_MERGE, "stack read stalled")

endmodule
`default_nettype wire

>>> dv/buddy_block_allocator_tb.sv
// self-checking testbench for the buddy block allocator
// depends on bba_pkg and the buddy_block_allocator rtl
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_tb;
    import bba_pkg::*;

    localparam int KIND_ALLOC = 0;
    localparam int KIND_FREE  = 1;
    localparam int MAX_CYCLES = 400000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;

    buddy_block_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // shadow allocator state
    bit        pool_free [NODE_COUNT];
    bit [7:0]  owned_start [ORDER_COUNT][$];
    int        units_left;

    in_t  pending_requests [$];
    out_t expected_results [$];
    int   error_count = 0;
    int   result_count = 0;
    int   cycle_count = 0;
    bit   quiet_tail;     // no idling near the end
    bit   hold_recv;      // long receiver hold-off request
    bit   hold_taken;
    int   send_gap;
    int   recv_gap;
    int   hold_cycles;
    int   status_seen [4];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int node_index(int k, int s);
        return (1 << (POOL_ORDER - k)) + (s >> k) - 1;
    endfunction

    function automatic int size_order(int size);
        int x;
        x = 0;
        while ((1 << x) < size) x++;
        return x;
    endfunction

    function automatic void pool_reset();
        foreach (pool_free[i]) pool_free[i] = 1'b0;
        foreach (owned_start[k]) owned_start[k].delete();
        pool_free[node_index(POOL_ORDER, 0)] = 1'b1;
        units_left = POOL_UNITS;
    endfunction

    // compute expected result and advance shadow state
    function automatic out_t allocate_or_release(in_t req);
        out_t r;
        int   x, j, s, k, m, buddy;
        bit   found;
        r = '0;
        r.status = ST_OK;
        if (req.request_size > POOL_UNITS) begin
            r.status = ST_TOO_BIG;
        end else begin
            x = size_order(req.request_size);
            if (req.kind == KIND_ALLOC) begin
                found = 1'b0;
                s = 0;
                for (j = x; j <= POOL_ORDER && !found; j++) begin
                    for (int i = 0; i < (1 << (POOL_ORDER - j)); i++) begin
                        if (pool_free[node_index(j, i << j)]) begin
                            s = i << j;
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found) break;
                end
                if (!found) begin
                    r.status = ST_NO_FREE;
                end else begin
                    pool_free[node_index(j, s)] = 1'b0;
                    // split down, upper halves stay free
                    while (j > x) begin
                        j--;
                        pool_free[node_index(j, s + (1 << j))] = 1'b1;
                    end
                    owned_start[x].push_back(s[7:0]);
                    units_left -= (1 << x);
                    r.block_start = s[7:0];
                    r.block_end = 8'(s + (1 << x) - 1);
                end
            end else begin
                if (owned_start[x].size() == 0) begin
                    r.status = ST_NONE;
                end else begin
                    s = owned_start[x].pop_back();
                    r.block_start = s[7:0];
                    r.block_end = 8'(s + (1 << x) - 1);
                    k = x;
                    m = s;
                    // coalesce while the true buddy is free
                    while (k < POOL_ORDER) begin
                        buddy = m ^ (1 << k);
                        if (!pool_free[node_index(k, buddy)]) break;
                        pool_free[node_index(k, buddy)] = 1'b0;
                        m &= ~(1 << k);
                        k++;
                    end
                    pool_free[node_index(k, m)] = 1'b1;
                    units_left += (1 << x);
                end
            end
        end
        r.available = units_left[SIZE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        error_count++;
    endtask

    function automatic in_t make_request(int kind, int size);
        in_t r;
        r.kind = kind[0];
        r.request_size = size[SIZE_W-1:0];
        return r;
    endfunction

    // sizes mostly small, a few large, some out of range
    function automatic int pick_size();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return $urandom_range(0, 16);
        if (p < 85) return $urandom_range(17, 128);
        if (p < 95) return $urandom_range(129, 256);
        return $urandom_range(257, 511);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                expected_results.push_back(allocate_or_release(in_data));
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_requests.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_requests.pop_front();
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready   <= 1'b0;
            recv_gap    <= 0;
            hold_cycles <= 0;
            hold_taken  <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    out_t want;
                    want = expected_results.pop_front();
                    status_seen[want.status]++;
                    if (out_data.status != want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.block_start != want.block_start)
                        report_mismatch("block_start", out_data.block_start,
                                        want.block_start);
                    if (out_data.block_end != want.block_end)
                        report_mismatch("block_end", out_data.block_end,
                                        want.block_end);
                    if (out_data.available != want.available)
                        report_mismatch("available", out_data.available,
                                        want.available);
                end
                result_count++;
            end
            if (hold_recv && !hold_taken) begin
                hold_taken  <= 1'b1;
                hold_cycles <= 300;
                out_ready   <= 1'b0;
            end else if (hold_cycles > 1) begin
                hold_cycles <= hold_cycles - 1;
            end else if (hold_cycles == 1) begin
                hold_cycles <= 0;
                out_ready   <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap  <= recv_gap - 1;
                out_ready <= (recv_gap == 1);
            end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                recv_gap  <= $urandom_range(1, 14);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int live;
        quiet_tail = 1'b0;
        hold_recv = 1'b0;
        rst_n = 1'b0;
        pool_reset();

        // directed: extremes, all error codes, exhaustion and full merge
        pending_requests.push_back(make_request(KIND_FREE, 1));
        pending_requests.push_back(make_request(KIND_ALLOC, 257));
        pending_requests.push_back(make_request(KIND_FREE, 511));
        pending_requests.push_back(make_request(KIND_ALLOC, 0));
        pending_requests.push_back(make_request(KIND_ALLOC, 1));
        pending_requests.push_back(make_request(KIND_ALLOC, 3));
        pending_requests.push_back(make_request(KIND_ALLOC, 128));
        pending_requests.push_back(make_request(KIND_ALLOC, 128));
        pending_requests.push_back(make_request(KIND_FREE, 128));
        pending_requests.push_back(make_request(KIND_FREE, 4));
        pending_requests.push_back(make_request(KIND_FREE, 0));
        pending_requests.push_back(make_request(KIND_FREE, 1));
        pending_requests.push_back(make_request(KIND_ALLOC, 256));
        pending_requests.push_back(make_request(KIND_ALLOC, 1));
        pending_requests.push_back(make_request(KIND_FREE, 256));
        pending_requests.push_back(make_request(KIND_FREE, 256));
        pending_requests.push_back(make_request(KIND_ALLOC, 255));
        pending_requests.push_back(make_request(KIND_FREE, 129));
        pending_requests.push_back(make_request(KIND_ALLOC, 64));
        pending_requests.push_back(make_request(KIND_ALLOC, 32));
        pending_requests.push_back(make_request(KIND_FREE, 64));
        pending_requests.push_back(make_request(KIND_FREE, 33));

        // random: allocations lean ahead of frees to build fragmentation
        live = 0;
        for (int n = 0; n < 2000; n++) begin
            if ($urandom_range(0, 99) < (live > 20 ? 40 : 60)) begin
                pending_requests.push_back(make_request(KIND_ALLOC, pick_size()));
                live++;
            end else begin
                pending_requests.push_back(make_request(KIND_FREE, pick_size()));
                if (live > 0) live--;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // long receiver hold-off while the sender keeps offering
        wait (result_count >= 200);
        @(posedge clk);
        hold_recv <= 1'b1;
        wait (result_count >= 1700);
        @(posedge clk);
        quiet_tail <= 1'b1;

        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_results.size() == 0);
        repeat (40) @(posedge clk);

        $display("covered %0d results: ok %0d, no free %0d, none held %0d, too big %0d",
                 result_count, status_seen[ST_OK], status_seen[ST_NO_FREE],
                 status_seen[ST_NONE], status_seen[ST_TOO_BIG]);
        $display("with random idling on both sides and a long output stall");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
